FILE: rtl/xsfb_pkg.sv
`default_nettype none
package xsfb_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam int SPRITE_BITS = 8;

  typedef struct packed {
    logic pixel_value;
    logic row_collision;
    logic sprite_collision;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/xsfb_if.sv
`default_nettype none
interface xsfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [3:0] row_offset;
  logic [7:0] sprite_byte;
  logic       last_row;

  modport source (
    output valid, command, pos_x, pos_y, row_offset, sprite_byte, last_row,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, row_offset, sprite_byte, last_row,
    output ready
  );
endinterface

interface xsfb_out_if;
  logic valid;
  logic ready;
  logic pixel_value;
  logic row_collision;
  logic sprite_collision;

  modport source (
    output valid, pixel_value, row_collision, sprite_collision,
    input  ready
  );
  modport sink (
    input  valid, pixel_value, row_collision, sprite_collision,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/xsfb_ram.sv
`default_nettype none
module xsfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/xsfb_row_xor.sv
`default_nettype none
module xsfb_row_xor #(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0]         word_in,
  input  wire logic [$clog2(WIDTH)-1:0] col,
  input  wire logic [7:0]               sprite_byte,
  output logic      [WIDTH-1:0]         word_out,
  output logic                          hit
);

  localparam int ColW = $clog2(WIDTH);

  logic [WIDTH-1:0] mask;

  always_comb begin
    logic [ColW-1:0] c;
    mask = '0;
    for (int i = 0; i < xsfb_pkg::SPRITE_BITS; i++) begin
      c = col + ColW'(i);
      if (sprite_byte[xsfb_pkg::SPRITE_BITS - 1 - i]) begin
        mask[c] = 1'b1;
      end
    end
  end

  assign hit      = |(word_in & mask);
  assign word_out = word_in ^ mask;

endmodule
`default_nettype wire

FILE: rtl/xor_sprite_framebuffer.sv
`default_nettype none
// An accepted item's operands are registered as its frame row is read (registered);
// the result is registered when the item finishes, once the output slot is free.
// A new item is accepted only in the idle state, after the last one has finished
// and written back its modified row. Clear drops all per-row valid flags at once.
// Reset marks every row invalid (reads as zero) and clears the collision flag.
module xor_sprite_framebuffer #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  xsfb_in_if.sink    in_ch,
  xsfb_out_if.source out_ch
);

  localparam int ColW = $clog2(SCREEN_WIDTH);
  localparam int RowW = $clog2(SCREEN_HEIGHT);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                     state_r, state_nxt;
  logic [1:0]               cmd_r;
  logic [ColW-1:0]          col_r;
  logic [RowW-1:0]          row_r;
  logic [7:0]               byte_r;
  logic                     last_r;
  logic [SCREEN_HEIGHT-1:0] valid_r, valid_nxt;
  logic                     sticky_r, sticky_nxt;
  logic                     out_valid_r;
  xsfb_pkg::result_t        result_r, result;

  logic                     accept, slot_free, done;
  logic [7:0]               row_sum;
  logic [RowW-1:0]          acc_row;
  logic [SCREEN_WIDTH-1:0]  rdata, stored_word, new_word;
  logic                     hit, ram_we;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign done        = (state_r == S_EXEC) && slot_free;

  assign row_sum = in_ch.pos_y + {4'b0000, in_ch.row_offset};
  assign acc_row = (in_ch.command == xsfb_pkg::CMD_DRAW) ? row_sum[RowW-1:0]
                                                         : in_ch.pos_y[RowW-1:0];

  assign ram_we = done && (cmd_r == xsfb_pkg::CMD_DRAW);

  xsfb_ram #(
    .WIDTH(SCREEN_WIDTH),
    .DEPTH(SCREEN_HEIGHT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(row_r),
    .wdata(new_word),
    .re   (accept),
    .raddr(acc_row),
    .rdata(rdata)
  );

  assign stored_word = valid_r[row_r] ? rdata : '0;

  xsfb_row_xor #(
    .WIDTH(SCREEN_WIDTH)
  ) u_row_xor (
    .word_in    (stored_word),
    .col        (col_r),
    .sprite_byte(byte_r),
    .word_out   (new_word),
    .hit        (hit)
  );

  always_comb begin
    result     = '0;
    sticky_nxt = sticky_r;
    valid_nxt  = valid_r;
    unique case (cmd_r)
      xsfb_pkg::CMD_CLEAR: begin
        if (done) begin
          valid_nxt = '0;
        end
      end
      xsfb_pkg::CMD_DRAW: begin
        result.row_collision    = hit;
        result.sprite_collision = hit || sticky_r;
        if (done) begin
          sticky_nxt     = last_r ? 1'b0 : (hit || sticky_r);
          valid_nxt[row_r] = 1'b1;
        end
      end
      xsfb_pkg::CMD_READ: begin
        result.pixel_value = stored_word[col_r];
      end
      xsfb_pkg::CMD_NOP: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      sticky_r <= sticky_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= xsfb_pkg::CMD_NOP;
    end else if (accept) begin
      cmd_r <= in_ch.command;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= in_ch.pos_x[ColW-1:0];
      row_r  <= acc_row;
      byte_r <= in_ch.sprite_byte;
      last_r <= in_ch.last_row;
    end
    if (done) begin
      result_r <= result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.pixel_value      = result_r.pixel_value;
  assign out_ch.row_collision    = result_r.row_collision;
  assign out_ch.sprite_collision = result_r.sprite_collision;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execution");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EXEC) && slot_free)
    else $error("frame memory written outside row update");

  a_last_clears_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done && (cmd_r == xsfb_pkg::CMD_DRAW) && last_r |=> !sticky_r)
    else $error("collision flag not cleared after last sprite row");

  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r)
    else $error("finished item produced no result");
`endif

endmodule
`default_nettype wire

FILE: tb/xor_sprite_framebuffer_checker.sv
module xor_sprite_framebuffer_checker #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  xsfb_in_if         in_ch,
  xsfb_out_if        out_ch,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0]       screen_rows [SCREEN_HEIGHT];
  logic              sprite_hit_sticky;
  xsfb_pkg::result_t pending_results [$];
  int                fail_count = 0;

  function automatic xsfb_pkg::result_t apply_command(
    input logic [1:0] cmd,
    input logic [7:0] x,
    input logic [7:0] y,
    input logic [3:0] offset,
    input logic [7:0] sprite,
    input logic       last
  );
    xsfb_pkg::result_t res;
    int                row;
    int                col;
    logic [63:0]       word;
    logic              hit;
    res = '0;
    hit = 1'b0;
    case (cmd)
      xsfb_pkg::CMD_CLEAR: begin
        for (int r = 0; r < SCREEN_HEIGHT; r++) screen_rows[r] = '0;
      end
      xsfb_pkg::CMD_DRAW: begin
        row  = (int'(y) + int'(offset)) % SCREEN_HEIGHT;
        word = screen_rows[row];
        for (int i = 0; i < xsfb_pkg::SPRITE_BITS; i++) begin
          if (sprite[xsfb_pkg::SPRITE_BITS-1-i]) begin
            col = (int'(x) + i) % SCREEN_WIDTH;
            if (word[col]) hit = 1'b1;
            word[col] = ~word[col];
          end
        end
        screen_rows[row]     = word;
        res.row_collision    = hit;
        res.sprite_collision = hit | sprite_hit_sticky;
        sprite_hit_sticky    = last ? 1'b0 : res.sprite_collision;
      end
      xsfb_pkg::CMD_READ: begin
        res.pixel_value = screen_rows[int'(y) % SCREEN_HEIGHT][int'(x) % SCREEN_WIDTH];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    xsfb_pkg::result_t got;
    xsfb_pkg::result_t want;
    if (!rst_n) begin
      for (int r = 0; r < SCREEN_HEIGHT; r++) screen_rows[r] = '0;
      sprite_hit_sticky = 1'b0;
      pending_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.pixel_value      = out_ch.pixel_value;
        got.row_collision    = out_ch.row_collision;
        got.sprite_collision = out_ch.sprite_collision;
        if (pending_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected result pix=%0b rc=%0b sc=%0b", $realtime,
                     got.pixel_value, got.row_collision, got.sprite_collision);
          end
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.pixel_value !== want.pixel_value ||
              got.row_collision !== want.row_collision ||
              got.sprite_collision !== want.sprite_collision) begin
            if (fail_count < 10) begin
              $display("%0t: expected pix=%0b rc=%0b sc=%0b, got pix=%0b rc=%0b sc=%0b",
                       $realtime, want.pixel_value, want.row_collision,
                       want.sprite_collision, got.pixel_value, got.row_collision,
                       got.sprite_collision);
            end
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(apply_command(in_ch.command, in_ch.pos_x, in_ch.pos_y,
                                                in_ch.row_offset, in_ch.sprite_byte,
                                                in_ch.last_row));
      end
    end
    mismatches  <= fail_count;
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/xor_sprite_framebuffer_tb.sv
module xor_sprite_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 400;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  bit   hold_request = 1'b0;
  bit   hold_taken = 1'b0;
  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;

  xsfb_in_if  in_bus ();
  xsfb_out_if out_bus ();

  xor_sprite_framebuffer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  xor_sprite_framebuffer_checker u_frame_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // Entered and left at a falling edge.
  task automatic send_item(
    input logic [1:0] cmd,
    input logic [7:0] x,
    input logic [7:0] y,
    input logic [3:0] offset,
    input logic [7:0] sprite,
    input logic       last
  );
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.command     = cmd;
    in_bus.pos_x       = x;
    in_bus.pos_y       = y;
    in_bus.row_offset  = offset;
    in_bus.sprite_byte = sprite;
    in_bus.last_row    = last;
    in_bus.valid       = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken    = 1'b1;
        out_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_bus.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("xor_sprite_framebuffer_tb failed");
    $finish;
  end

  initial begin
    int         sent;
    int         pick;
    int         rows;
    int         burst;
    logic [1:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    in_bus.valid       = 1'b0;
    in_bus.command     = xsfb_pkg::CMD_CLEAR;
    in_bus.pos_x       = '0;
    in_bus.pos_y       = '0;
    in_bus.row_offset  = '0;
    in_bus.sprite_byte = '0;
    in_bus.last_row    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: wrapping on both axes, the sticky collision across rows,
    // an empty sprite byte, the unused command, and reads around a clear.
    send_item(xsfb_pkg::CMD_CLEAR, 8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_DRAW,  8'd0,   8'd0,   4'd0,  8'hFF, 1'b0);
    send_item(xsfb_pkg::CMD_DRAW,  8'd0,   8'd255, 4'd1,  8'h80, 1'b0);
    send_item(xsfb_pkg::CMD_DRAW,  8'd100, 8'd10,  4'd2,  8'h00, 1'b1);
    send_item(xsfb_pkg::CMD_DRAW,  8'd60,  8'd31,  4'd3,  8'h81, 1'b1);
    send_item(xsfb_pkg::CMD_READ,  8'd3,   8'd2,   4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_READ,  8'd61,  8'd34,  4'd15, 8'hFF, 1'b1);
    send_item(xsfb_pkg::CMD_READ,  8'd255, 8'd255, 4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_DRAW,  8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
    send_item(xsfb_pkg::CMD_READ,  8'd63,  8'd14,  4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd46,  4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_NOP,   8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
    send_item(xsfb_pkg::CMD_DRAW,  8'd0,   8'd0,   4'd0,  8'hFF, 1'b1);
    send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_DRAW,  8'd64,  8'd32,  4'd0,  8'hFF, 1'b0);
    send_item(xsfb_pkg::CMD_DRAW,  8'd64,  8'd32,  4'd1,  8'hFF, 1'b1);
    send_item(xsfb_pkg::CMD_CLEAR, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
    send_item(xsfb_pkg::CMD_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_READ,  8'd63,  8'd14,  4'd0,  8'h00, 1'b0);
    send_item(xsfb_pkg::CMD_DRAW,  8'd8,   8'd5,   4'd0,  8'hAA, 1'b1);
    send_item(xsfb_pkg::CMD_DRAW,  8'd8,   8'd5,   4'd0,  8'h55, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          hold_request       = 1'b1;
        end
        1: begin
          sender_idle_pct    = 76;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 76;
        end
        default: begin
          sender_idle_pct    = 16;
          receiver_stall_pct = 16;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          rows = $urandom_range(1, 15);
          x    = 8'($urandom_range(0, 255));
          y    = 8'($urandom_range(0, 255));
          for (int r = 0; r < rows; r++) begin
            send_item(xsfb_pkg::CMD_DRAW, x, y, r[3:0], 8'($urandom_range(0, 255)),
                      r == rows - 1);
          end
          sent += rows;
        end else if (pick < 88) begin
          burst = $urandom_range(1, 8);
          repeat (burst) begin
            send_item(xsfb_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
          sent += burst;
        end else if (pick < 99) begin
          cmd = 2'($urandom_range(1, 3));
          send_item(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
          if (cmd != xsfb_pkg::CMD_NOP) sent++;
        end else begin
          send_item(xsfb_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end

    in_bus.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("xor_sprite_framebuffer_tb passed");
    end else begin
      $display("xor_sprite_framebuffer_tb failed");
    end
    $finish;
  end

endmodule
